@@ design/wzis_pkg.sv @@
// shared types, codes and constants of the weekly zone irrigation scheduler
`default_nettype none

package wzis_pkg;

  localparam int DEF_NUM_ENTRIES = 8;
  localparam int DEF_ZONE_COUNT  = 8;

  localparam int S_DATA_W = 96;
  localparam int M_DATA_W = 16;
  localparam int STAMP_W  = 32;
  localparam int MAX_EVENTS = 16;
  localparam int EVCNT_W  = $clog2(MAX_EVENTS + 1);

  localparam logic        OP_WRITE = 1'b0;
  localparam logic        OP_TICK  = 1'b1;
  localparam logic [1:0]  STAT_OFF = 2'd0;
  localparam logic [1:0]  STAT_ON  = 2'd1;
  localparam logic        KIND_START = 1'b0;
  localparam logic        KIND_STOP  = 1'b1;
  localparam logic [15:0] MS_PER_MIN   = 16'd60000;
  localparam logic [10:0] MAX_DURATION = 11'd1439;

  // one schedule entry as held in the table memory
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  zones;
    logic [6:0]  days;
    logic [10:0] dur;
    logic [10:0] smin;
  } cfg_t;

  localparam int CFG_W = $bits(cfg_t);

  typedef struct packed {
    logic        op;
    logic [2:0]  entry_index;
    logic        entry_valid;
    logic [10:0] start_minute;
    logic [10:0] duration_minutes;
    logic [6:0]  day_mask;
    logic [7:0]  zone_mask;
    logic [1:0]  entry_status;
    logic [10:0] minute_of_day;
    logic [2:0]  weekday;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [2:0] entry;
    logic       kind;
    logic [7:0] zones;
    logic       pump;
  } event_t;

  // scanner to event queue
  typedef struct packed {
    logic   push;
    logic   flush;
    event_t ev;
  } evq_ctl_t;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_READ,
    SC_EVAL,
    SC_PUSH_START,
    SC_PUSH_STOP,
    SC_FLUSH
  } scan_state_t;

endpackage

`default_nettype wire

@@ design/wzis_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module wzis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/wzis_evq.sv @@
// event queue: one held word for end-of-tick marking, output register, event cap
`default_nettype none

module wzis_evq
  import wzis_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire evq_ctl_t ctl,
  output logic          ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output event_t        out_ev,
  output logic          out_last
);

  logic               pend_valid;
  event_t             pend;
  logic [EVCNT_W-1:0] cnt;
  logic               out_free;
  logic               push_ok;
  logic               flush_ok;
  logic               load;

  assign out_free = !out_valid || out_ready;
  assign ready    = !pend_valid || out_free;
  // words beyond the cap still count as taken, they are just dropped
  assign push_ok  = ctl.push && ready && (cnt < EVCNT_W'(MAX_EVENTS));
  assign flush_ok = ctl.flush && ready;
  assign load     = (push_ok || flush_ok) && pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      cnt        <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (push_ok) begin
        pend_valid <= 1'b1;
        cnt        <= cnt + 1'b1;
      end else if (flush_ok) begin
        pend_valid <= 1'b0;
        cnt        <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ev   <= pend;
      out_last <= flush_ok;
    end
    if (push_ok) begin
      pend <= ctl.ev;
    end
  end

endmodule

`default_nettype wire

@@ design/wzis_scan.sv @@
// table writes and per-tick scan sequencer over the entry memories
`default_nettype none

module wzis_scan
  import wzis_pkg::*;
#(
  parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
  parameter int ZONE_COUNT  = DEF_ZONE_COUNT,
  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire item_t              in_item,
  output logic                    cfg_we,
  output logic [IDX_W-1:0]        cfg_waddr,
  output cfg_t                    cfg_wdata,
  output logic [IDX_W-1:0]        cfg_raddr,
  input  wire cfg_t               cfg_rdata,
  output logic                    stamp_we,
  output logic [IDX_W-1:0]        stamp_waddr,
  output logic [STAMP_W-1:0]      stamp_wdata,
  output logic [IDX_W-1:0]        stamp_raddr,
  input  wire logic [STAMP_W-1:0] stamp_rdata,
  output evq_ctl_t                ctl,
  input  wire logic               evq_ready
);

  localparam logic [7:0] ZONE_MASK =
    (ZONE_COUNT >= 8) ? 8'hFF : 8'((1 << ZONE_COUNT) - 1);

  scan_state_t state, state_next;

  logic [IDX_W-1:0]       idx;
  logic [NUM_ENTRIES-1:0] valid;
  logic [NUM_ENTRIES-1:0] running;
  logic [NUM_ENTRIES-1:0] stamp_ok;
  logic [10:0]            tick_minute;
  logic [2:0]             tick_wd;
  logic [STAMP_W-1:0]     tick_now;
  logic                   ev_stop;
  logic [7:0]             ev_zones;

  logic                   accept;
  logic                   wr_hit;
  logic [IDX_W-1:0]       wr_idx;
  logic                   last_idx;
  logic                   advance;
  logic                   cur_valid;
  logic                   cur_run;
  logic [STAMP_W-1:0]     stamp_cur;
  logic [7:0]             day_vec;
  logic                   start_hit;
  logic                   stop_hit;
  logic [26:0]            need;
  logic [STAMP_W-1:0]     elapsed;
  cfg_t                   new_cfg;

  assign accept   = in_valid && in_ready;
  assign wr_hit   = (in_item.op == OP_WRITE) && (int'(in_item.entry_index) < NUM_ENTRIES);
  assign wr_idx   = IDX_W'(in_item.entry_index);
  assign last_idx = (idx == IDX_W'(NUM_ENTRIES - 1));

  assign cfg_raddr   = idx;
  assign stamp_raddr = idx;

  // entry evaluation on the word read in the previous cycle
  assign cur_valid = valid[idx];
  assign cur_run   = running[idx];
  assign stamp_cur = stamp_ok[idx] ? stamp_rdata : '0;
  assign day_vec   = {1'b0, cfg_rdata.days};
  assign start_hit = cur_valid && !cur_run && (cfg_rdata.status == STAT_OFF) &&
                     (cfg_rdata.smin == tick_minute) && day_vec[tick_wd];
  assign need      = 27'(cfg_rdata.dur) * 27'(MS_PER_MIN);
  assign elapsed   = tick_now - stamp_cur;
  // a fresh start has zero elapsed time
  assign stop_hit  = cur_valid &&
                     (start_hit ? (cfg_rdata.dur == '0)
                                : (cur_run && (elapsed >= {5'd0, need})));

  always_comb begin
    new_cfg.status = in_item.entry_status;
    new_cfg.zones  = in_item.zone_mask;
    new_cfg.days   = in_item.day_mask;
    new_cfg.dur    = (in_item.duration_minutes > MAX_DURATION) ? MAX_DURATION
                                                              : in_item.duration_minutes;
    new_cfg.smin   = in_item.start_minute;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    in_ready         = 1'b0;
    cfg_we           = 1'b0;
    cfg_waddr        = idx;
    cfg_wdata        = cfg_rdata;
    stamp_we         = 1'b0;
    stamp_waddr      = idx;
    stamp_wdata      = tick_now;
    advance          = 1'b0;
    ctl.push         = 1'b0;
    ctl.flush        = 1'b0;
    ctl.ev.entry     = 3'(idx);
    ctl.ev.kind      = KIND_START;
    ctl.ev.zones     = ev_zones;
    ctl.ev.pump      = 1'b1;
    unique case (state)
      SC_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          if (in_item.op == OP_TICK) begin
            state_next = SC_READ;
          end else if (wr_hit && in_item.entry_valid) begin
            cfg_we    = 1'b1;
            cfg_waddr = wr_idx;
            cfg_wdata = new_cfg;
          end
        end
      end
      SC_READ: begin
        state_next = SC_EVAL;
      end
      SC_EVAL: begin
        cfg_we           = start_hit || stop_hit;
        cfg_wdata.status = (start_hit && !stop_hit) ? STAT_ON : STAT_OFF;
        stamp_we         = start_hit;
        if (start_hit) begin
          state_next = SC_PUSH_START;
        end else if (stop_hit) begin
          state_next = SC_PUSH_STOP;
        end else begin
          advance = 1'b1;
        end
      end
      SC_PUSH_START: begin
        ctl.push = 1'b1;
        if (evq_ready) begin
          if (ev_stop) begin
            state_next = SC_PUSH_STOP;
          end else begin
            advance = 1'b1;
          end
        end
      end
      SC_PUSH_STOP: begin
        ctl.push    = 1'b1;
        ctl.ev.kind = KIND_STOP;
        ctl.ev.pump = 1'b0;
        if (evq_ready) begin
          advance = 1'b1;
        end
      end
      SC_FLUSH: begin
        ctl.flush = 1'b1;
        if (evq_ready) begin
          state_next = SC_IDLE;
        end
      end
      default: begin
        state_next = SC_IDLE;
      end
    endcase
    if (advance) begin
      state_next = last_idx ? SC_FLUSH : SC_READ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      valid    <= '0;
      running  <= '0;
      stamp_ok <= '0;
    end else begin
      if (accept && (in_item.op == OP_TICK)) begin
        idx <= '0;
      end else if (advance && !last_idx) begin
        idx <= idx + 1'b1;
      end
      if (accept && wr_hit) begin
        valid[wr_idx]   <= in_item.entry_valid;
        running[wr_idx] <= in_item.entry_valid && (in_item.entry_status == STAT_ON);
      end
      if ((state == SC_EVAL) && cur_valid) begin
        running[idx] <= start_hit ? !stop_hit : (cur_run && !stop_hit);
        if (start_hit) begin
          stamp_ok[idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_item.op == OP_TICK)) begin
      tick_minute <= in_item.minute_of_day;
      tick_wd     <= in_item.weekday;
      tick_now    <= in_item.now_ms;
    end
    if (state == SC_EVAL) begin
      ev_stop  <= stop_hit;
      ev_zones <= cfg_rdata.zones & ZONE_MASK;
    end
  end

endmodule

`default_nettype wire

@@ design/weekly_zone_irrigation_scheduler_unit.sv @@
// top level of the weekly zone irrigation scheduler
// a table write gives no word and leaves the scanner idle; the next item is taken in the cycle after
// a tick scans the entries in turn through table and stamp memories with one write port each:
// a read state and an evaluate/write-back state per entry, a push state per event word
// (held while the event queue is not ready) and a closing flush state
// each event word leaves once the next one of its tick is known; the last leaves at the close
// rst clears the control state and the valid, running and stamp flags; memories keep contents
`default_nettype none

module weekly_zone_irrigation_scheduler_unit
  import wzis_pkg::*;
#(
  parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
  parameter int ZONE_COUNT  = DEF_ZONE_COUNT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // input words
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // entry_index, entry_valid, start_minute, duration_minutes, day_mask, zone_mask,
  // entry_status, minute_of_day, weekday, now_ms, zero fill
  input  wire logic [S_DATA_W-1:0] s_tdata,
  // op
  input  wire logic                s_tuser,
  // event words
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // event_entry, zones_switched, pump_on, zero fill
  output logic [M_DATA_W-1:0]      m_tdata,
  // event_kind
  output logic                     m_tuser,
  output logic                     m_tlast
);

  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  item_t              item;
  logic               cfg_we;
  logic [IDX_W-1:0]   cfg_waddr;
  cfg_t               cfg_wdata;
  logic [IDX_W-1:0]   cfg_raddr;
  cfg_t               cfg_rdata;
  logic               stamp_we;
  logic [IDX_W-1:0]   stamp_waddr;
  logic [STAMP_W-1:0] stamp_wdata;
  logic [IDX_W-1:0]   stamp_raddr;
  logic [STAMP_W-1:0] stamp_rdata;
  evq_ctl_t           ctl;
  logic               evq_ready;
  event_t             out_ev;

  // unpack the input word, first field in the low bits
  assign item.op               = s_tuser;
  assign item.entry_index      = s_tdata[2:0];
  assign item.entry_valid      = s_tdata[3];
  assign item.start_minute     = s_tdata[14:4];
  assign item.duration_minutes = s_tdata[25:15];
  assign item.day_mask         = s_tdata[32:26];
  assign item.zone_mask        = s_tdata[40:33];
  assign item.entry_status     = s_tdata[42:41];
  assign item.minute_of_day    = s_tdata[53:43];
  assign item.weekday          = s_tdata[56:54];
  assign item.now_ms           = s_tdata[88:57];

  // sequencer: writes, scan, start/stop decisions
  wzis_scan #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .ZONE_COUNT  (ZONE_COUNT)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_item     (item),
    .cfg_we      (cfg_we),
    .cfg_waddr   (cfg_waddr),
    .cfg_wdata   (cfg_wdata),
    .cfg_raddr   (cfg_raddr),
    .cfg_rdata   (cfg_rdata),
    .stamp_we    (stamp_we),
    .stamp_waddr (stamp_waddr),
    .stamp_wdata (stamp_wdata),
    .stamp_raddr (stamp_raddr),
    .stamp_rdata (stamp_rdata),
    .ctl         (ctl),
    .evq_ready   (evq_ready)
  );

  // schedule table: start minute, duration, days, zones, status
  wzis_ram #(
    .WIDTH (CFG_W),
    .DEPTH (NUM_ENTRIES)
  ) u_cfg_ram (
    .clk   (clk),
    .we    (cfg_we),
    .waddr (cfg_waddr),
    .wdata (cfg_wdata),
    .raddr (cfg_raddr),
    .rdata (cfg_rdata)
  );

  // start stamps, read as zero until the entry first starts
  wzis_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (NUM_ENTRIES)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (stamp_waddr),
    .wdata (stamp_wdata),
    .raddr (stamp_raddr),
    .rdata (stamp_rdata)
  );

  // holds one event back so the last of a tick can be marked
  wzis_evq u_evq (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .ready     (evq_ready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_ev    (out_ev),
    .out_last  (m_tlast)
  );

  assign m_tdata = {4'd0, out_ev.pump, out_ev.zones, out_ev.entry};
  assign m_tuser = out_ev.kind;

endmodule

`default_nettype wire

@@ design/wzis_checker.sv @@
// port-level checks of the scheduler and their binding to the top level
`default_nettype none

module wzis_checker
  import wzis_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_tvalid,
  input wire logic                s_tready,
  input wire logic [S_DATA_W-1:0] s_tdata,
  input wire logic                s_tuser,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic [M_DATA_W-1:0] m_tdata,
  input wire logic                m_tuser,
  input wire logic                m_tlast
);

  // no event word survives reset
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("event word valid after reset");

  // a stalled event word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("stalled event word changed");

  // starts switch the pump on, stops switch it off
  a_pump_follows_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[11] != m_tuser))
    else $error("pump command does not match event kind");

  // a tick occupies the scanner, no word is taken right after it
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == OP_TICK) |=> !s_tready)
    else $error("input taken while a tick scan runs");

endmodule

bind weekly_zone_irrigation_scheduler_unit wzis_checker u_wzis_checker (.*);

`default_nettype wire
